// ===== sv/cbcd_pkg.sv =====
// shared types, constants, microcode table and arithmetic helpers for the biquad decimator
package cbcd_pkg;

  localparam int SECTIONS_DEF = 4;
  localparam int SAMPLE_W     = 16;
  localparam int OUT_W        = 56;
  localparam int ACC_W        = 64;
  localparam int FRAC_W       = 16;
  localparam int COEF_W       = 32;
  localparam int COEF_FRAC    = 30;
  localparam int DECIM_W      = 13;
  localparam int PHASE_W      = 12;
  localparam int MAX_DECIM    = 4096;
  localparam int PC_W         = 4;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // program steps
  localparam logic [PC_W-1:0] STEP_LD1  = 4'd0;
  localparam logic [PC_W-1:0] STEP_MH1  = 4'd1;
  localparam logic [PC_W-1:0] STEP_ML1  = 4'd2;
  localparam logic [PC_W-1:0] STEP_RND1 = 4'd3;
  localparam logic [PC_W-1:0] STEP_MH2  = 4'd4;
  localparam logic [PC_W-1:0] STEP_ML2  = 4'd5;
  localparam logic [PC_W-1:0] STEP_RND2 = 4'd6;
  localparam logic [PC_W-1:0] STEP_ACC2 = 4'd7;
  localparam logic [PC_W-1:0] STEP_Y1   = 4'd8;
  localparam logic [PC_W-1:0] STEP_Y2   = 4'd9;
  localparam logic [PC_W-1:0] STEP_OUT  = 4'd10;

  typedef struct packed {
    logic            ld;      // load operand magnitude and coefficient
    logic            zsel;    // 0: first delay word / a1, 1: second delay word / a2
    logic            mul;     // run the partial product multiplier
    logic            mul_hi;  // upper half of the operand
    logic            rnd;     // round, saturate and negate the product
    logic            acc;     // accumulate the negated product into w
    logic            acc_x;   // accumulate starting from the section input
    logic            y1;      // y = w + 2*z1
    logic            y2;      // y += z2, shift delay words
    logic            loop;    // jump to tgt unless this is the last section
    logic            out;     // hand the result to the output register
    logic [PC_W-1:0] tgt;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic ld;
    logic zsel;
    logic mul;
    logic mul_hi;
    logic rnd;
    logic acc;
    logic acc_x;
    logic y1;
    logic y2;
  } lane_ctrl_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '0;
    unique case (pc)
      STEP_LD1:  begin
        w.ld = 1'b1;
      end
      STEP_MH1:  begin
        w.mul = 1'b1;
        w.mul_hi = 1'b1;
      end
      STEP_ML1:  begin
        w.mul = 1'b1;
      end
      STEP_RND1: begin
        w.rnd = 1'b1;
        w.ld = 1'b1;
        w.zsel = 1'b1;
      end
      STEP_MH2:  begin
        w.mul = 1'b1;
        w.mul_hi = 1'b1;
      end
      STEP_ML2:  begin
        w.mul = 1'b1;
        w.acc = 1'b1;
        w.acc_x = 1'b1;
      end
      STEP_RND2: begin
        w.rnd = 1'b1;
      end
      STEP_ACC2: begin
        w.acc = 1'b1;
      end
      STEP_Y1:   begin
        w.y1 = 1'b1;
      end
      STEP_Y2:   begin
        w.y2 = 1'b1;
        w.loop = 1'b1;
        w.tgt = STEP_LD1;
      end
      default:   begin
        w.out = 1'b1;
      end
    endcase
    return w;
  endfunction

  // feedback coefficients, Q2.30
  function automatic logic signed [COEF_W-1:0] coef_f(input logic [1:0] row, input logic sel);
    logic signed [COEF_W-1:0] c;
    unique case (row)
      2'd0: c = sel ? 32'sd1062038038 : -32'sd2109687936;
      2'd1: c = sel ? 32'sd1040670576 : -32'sd2095621918;
      2'd2: c = sel ? 32'sd1024564448 : -32'sd2089501590;
      2'd3: c = sel ? 32'sd1015867140 : -32'sd2087783603;
    endcase
    return c;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] r;
    r = a + b;
    if (!a[ACC_W-1] && !b[ACC_W-1] && r[ACC_W-1]) r = ACC_MAX;
    else if (a[ACC_W-1] && b[ACC_W-1] && !r[ACC_W-1]) r = ACC_MIN;
    return r;
  endfunction

endpackage

// ===== sv/cbcd_lane.sv =====
// one rail of the biquad cascade: delay words and the shared multiply-accumulate datapath
module cbcd_lane #(
  parameter int SECTIONS = cbcd_pkg::SECTIONS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cbcd_pkg::lane_ctrl_t                  ctrl_i,
  input  logic [((SECTIONS > 1) ? $clog2(SECTIONS) : 1)-1:0] sec_i,
  input  logic signed [cbcd_pkg::SAMPLE_W-1:0]  sample_i,
  output logic signed [cbcd_pkg::OUT_W-1:0]     y_o
);

  localparam int AW = cbcd_pkg::ACC_W;
  localparam int CW = cbcd_pkg::COEF_W;
  localparam int HW = AW / 2;

  logic signed [AW-1:0] z1_q [SECTIONS];
  logic signed [AW-1:0] z2_q [SECTIONS];

  logic signed [AW-1:0] x_q, w_q, nm_q;
  logic [AW-1:0]        mag_q, p_hi_q, p_lo_q;
  logic [CW-1:0]        cmag_q;
  logic                 neg_q;

  logic signed [AW-1:0] z1_s, z2_s, zv, z1_dbl, nm_d, acc_src;
  logic signed [CW-1:0] coef;
  logic [HW-1:0]        mul_a;
  logic [AW-1:0]        prod, rnd_sum, m64;
  logic [AW:0]          m65;
  logic                 ovf;

  assign z1_s = z1_q[sec_i];
  assign z2_s = z2_q[sec_i];
  assign zv   = ctrl_i.zsel ? z2_s : z1_s;
  assign coef = cbcd_pkg::coef_f(2'(sec_i), ctrl_i.zsel);

  // one 32x32 unsigned partial product per cycle on the multiply steps
  assign mul_a = ctrl_i.mul_hi ? mag_q[AW-1:HW] : mag_q[HW-1:0];
  assign prod  = AW'(mul_a) * AW'(cmag_q);

  // recombine partial products, round half away from zero at bit 30
  assign rnd_sum = p_lo_q + (AW'(1) << (cbcd_pkg::COEF_FRAC - 1));
  assign m65 = {2'b00, p_hi_q[AW-4:0], 2'b00}
             + (AW+1)'(rnd_sum[AW-1:cbcd_pkg::COEF_FRAC]);
  assign ovf = (|p_hi_q[AW-1:AW-3]) | m65[AW] | m65[AW-1];
  assign m64 = m65[AW-1:0];
  // negated product, saturated like a saturating negate of the saturated product
  assign nm_d = ovf ? (neg_q ? cbcd_pkg::ACC_MAX : cbcd_pkg::ACC_MIN + AW'(1))
                    : (neg_q ? signed'(m64) : signed'(AW'(0) - m64));

  assign acc_src = ctrl_i.acc_x ? x_q : w_q;
  assign z1_dbl  = (z1_s[AW-1] != z1_s[AW-2])
                 ? (z1_s[AW-1] ? cbcd_pkg::ACC_MIN : cbcd_pkg::ACC_MAX)
                 : (z1_s <<< 1);

  // round half up to integer units; the 48-bit quotient never reaches the 56-bit limits
  assign y_o = cbcd_pkg::OUT_W'(x_q >>> cbcd_pkg::FRAC_W)
             + cbcd_pkg::OUT_W'(x_q[cbcd_pkg::FRAC_W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SECTIONS; i++) begin
        z1_q[i] <= '0;
        z2_q[i] <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < SECTIONS; i++) begin
        z1_q[i] <= '0;
        z2_q[i] <= '0;
      end
    end else if (ctrl_i.y2) begin
      z2_q[sec_i] <= z1_s;
      z1_q[sec_i] <= w_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      x_q <= {{(AW-cbcd_pkg::SAMPLE_W-cbcd_pkg::FRAC_W){sample_i[cbcd_pkg::SAMPLE_W-1]}},
              sample_i, cbcd_pkg::FRAC_W'(0)};
    end else if (ctrl_i.y1) begin
      x_q <= cbcd_pkg::sat_add(w_q, z1_dbl);
    end else if (ctrl_i.y2) begin
      x_q <= cbcd_pkg::sat_add(x_q, z2_s);
    end
    if (ctrl_i.ld) begin
      mag_q  <= zv[AW-1] ? (AW'(0) - unsigned'(zv)) : unsigned'(zv);
      cmag_q <= coef[CW-1] ? (CW'(0) - unsigned'(coef)) : unsigned'(coef);
      neg_q  <= zv[AW-1] ^ coef[CW-1];
    end
    if (ctrl_i.mul) begin
      if (ctrl_i.mul_hi) p_hi_q <= prod;
      else               p_lo_q <= prod;
    end
    if (ctrl_i.rnd) nm_q <= nm_d;
    if (ctrl_i.acc) w_q <= cbcd_pkg::sat_add(acc_src, nm_q);
  end

endmodule

// ===== sv/complex_biquad_cascade_decimator.sv =====
// top level: microcoded sequencer, phase counter and output register of the complex decimator
// the result word is written to the output register at the output step, after every section has run
// a new input word is accepted only once the program for the previous word has finished; the
//   ten-step section program shares one 32x32 multiplier per rail over both products
// an emitting word may hold the program on its last step until the output register frees
// reset: asynchronous, active low; delay words and phase count clear, the decimation register reads 1
module complex_biquad_cascade_decimator #(
  parameter int SECTIONS = cbcd_pkg::SECTIONS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [cbcd_pkg::SAMPLE_W-1:0]   sample_re_i,
  input  logic signed [cbcd_pkg::SAMPLE_W-1:0]   sample_im_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [cbcd_pkg::OUT_W-1:0]      out_re_o,
  output logic signed [cbcd_pkg::OUT_W-1:0]      out_im_o,
  input  logic                                   cfg_we_i,
  input  logic [cbcd_pkg::DECIM_W-1:0]           cfg_data_i
);

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int DW    = cbcd_pkg::DECIM_W;
  localparam int PW    = cbcd_pkg::PHASE_W;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                          state_q;
  logic [cbcd_pkg::PC_W-1:0]       pc_q;
  logic [SEC_W-1:0]                k_q;
  logic                            emit_q;
  logic [PW-1:0]                   phase_q;
  logic [DW-1:0]                   decim_q;
  logic                            out_valid_q;
  logic signed [cbcd_pkg::OUT_W-1:0] out_re_q, out_im_q;

  cbcd_pkg::ucode_t     uw;
  cbcd_pkg::lane_ctrl_t ctrl;
  logic                 run, accept, out_ok, last_sec, emit_d, load_out;
  logic [DW-1:0]        d_eff, phase_inc;
  logic signed [cbcd_pkg::OUT_W-1:0] y_re, y_im;

  // current control word
  assign uw  = cbcd_pkg::ucode_rom(pc_q);
  assign run = (state_q == ST_RUN);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_ok      = !out_valid_q || !out_stall_i;
  assign last_sec    = (k_q == SEC_W'(SECTIONS - 1));
  // output step of an emitting word with room in the output register
  assign load_out    = run && uw.out && emit_q && out_ok;
  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;

  // divisor of zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (decim_q == '0)                       d_eff = DW'(1);
    else if (decim_q > DW'(cbcd_pkg::MAX_DECIM)) d_eff = DW'(cbcd_pkg::MAX_DECIM);
    else                                      d_eff = decim_q;
  end
  assign phase_inc = DW'(phase_q) + DW'(1);
  assign emit_d    = (phase_inc >= d_eff);

  // both rails run the same program in lockstep
  always_comb begin
    ctrl        = '0;
    ctrl.start  = accept;
    ctrl.clear  = cfg_we_i;
    ctrl.ld     = run && uw.ld;
    ctrl.zsel   = uw.zsel;
    ctrl.mul    = run && uw.mul;
    ctrl.mul_hi = uw.mul_hi;
    ctrl.rnd    = run && uw.rnd;
    ctrl.acc    = run && uw.acc;
    ctrl.acc_x  = uw.acc_x;
    ctrl.y1     = run && uw.y1;
    ctrl.y2     = run && uw.y2;
  end

  cbcd_lane #(
    .SECTIONS(SECTIONS)
  ) u_lane_re (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .sec_i   (k_q),
    .sample_i(sample_re_i),
    .y_o     (y_re)
  );

  cbcd_lane #(
    .SECTIONS(SECTIONS)
  ) u_lane_im (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .sec_i   (k_q),
    .sample_i(sample_im_i),
    .y_o     (y_im)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= cbcd_pkg::STEP_LD1;
      k_q         <= '0;
      emit_q      <= 1'b0;
      phase_q     <= '0;
      decim_q     <= DW'(1);
      out_valid_q <= 1'b0;
      out_re_q    <= '0;
      out_im_q    <= '0;
    end else begin
      // new output word loaded, or the held one taken
      if (load_out) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      // register write clears the phase; the lanes clear their delay words
      if (cfg_we_i) begin
        decim_q <= cfg_data_i;
        phase_q <= '0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_RUN;
            pc_q    <= cbcd_pkg::STEP_LD1;
            k_q     <= '0;
            emit_q  <= emit_d;
            if (!cfg_we_i) phase_q <= emit_d ? '0 : phase_inc[PW-1:0];
          end
        end
        ST_RUN: begin
          if (uw.loop) begin
            // next section or fall through to the output step
            if (!last_sec) begin
              pc_q <= uw.tgt;
              k_q  <= k_q + SEC_W'(1);
            end else begin
              pc_q <= pc_q + cbcd_pkg::PC_W'(1);
              k_q  <= '0;
            end
          end else if (uw.out) begin
            if (!emit_q) begin
              state_q <= ST_IDLE;
            end else if (out_ok) begin
              out_re_q <= y_re;
              out_im_q <= y_im;
              state_q  <= ST_IDLE;
            end
          end else begin
            pc_q <= pc_q + cbcd_pkg::PC_W'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // a result word only appears from the output step of an emitting word
  a_out_from_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RUN && uw.out && emit_q))
    else $error("output word without an emitting program step");

  // the phase count always stays below the effective divisor
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DW'(phase_q) < d_eff))
    else $error("phase count reached the divisor");

  // section index stays inside the cascade while the program runs
  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run |-> (k_q <= SEC_W'(SECTIONS - 1)))
    else $error("section index out of range");

  // an emitting word waiting on a full output register keeps the input side stalled
  a_hold_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run && uw.out && emit_q && !out_ok) |=> (state_q == ST_RUN && in_stall_o))
    else $error("program left the output step while the result could not be stored");

endmodule
